FILE: hdl/leso_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leso_pkg
// Shared types and constants for the linear observer controller.
// ----------------------------------------------------------------------------
package leso_pkg;

    localparam int DW = 32;
    localparam int FB = 16;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_THR,
        ST_KH,
        ST_FILT,
        ST_WGT,
        ST_BW,
        ST_BWU,
        ST_POS,
        ST_GE,
        ST_LW,
        ST_DLIM,
        ST_CLMP,
        ST_KP,
        ST_DIV,
        ST_DIVW,
        ST_COMP,
        ST_OUT
    } state_t;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_THR,
        OP_KH,
        OP_FILT,
        OP_WGT,
        OP_BW,
        OP_BWU,
        OP_POS,
        OP_GE,
        OP_LW,
        OP_DLIM,
        OP_CLMP,
        OP_KP,
        OP_DIVS,
        OP_COMP
    } op_t;

    typedef struct packed {
        op_t  op;
        logic load;
    } cmd_t;

    typedef struct packed {
        logic div_busy;
    } status_t;

    localparam logic [2:0] REG_STEP = 3'd0;
    localparam logic [2:0] REG_DG   = 3'd1;
    localparam logic [2:0] REG_MG   = 3'd2;
    localparam logic [2:0] REG_DZ   = 3'd3;
    localparam logic [2:0] REG_EL   = 3'd4;
    localparam logic [2:0] REG_KP   = 3'd5;
    localparam logic [2:0] REG_OL   = 3'd6;
    localparam logic [2:0] REG_UOE  = 3'd7;

endpackage
`default_nettype wire

FILE: hdl/leso_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leso_ctrl
// Sequencer that steps the datapath through one sample.
// ----------------------------------------------------------------------------
module leso_ctrl
    import leso_pkg::*;
(
    input  wire logic    aclk,
    input  wire logic    aresetn,
    input  wire logic    in_valid,
    output logic         in_ready,
    output logic         out_valid,
    input  wire logic    out_ready,
    input  wire status_t stat,
    output cmd_t         cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd.op     = OP_NONE;
        cmd.load   = 1'b0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                in_ready = 1'b1;
                cmd.load = in_valid;
                if (in_valid) state_next = ST_THR;
            end
            ST_THR:  begin cmd.op = OP_THR;  state_next = ST_KH;   end
            ST_KH:   begin cmd.op = OP_KH;   state_next = ST_FILT; end
            ST_FILT: begin cmd.op = OP_FILT; state_next = ST_WGT;  end
            ST_WGT:  begin cmd.op = OP_WGT;  state_next = ST_BW;   end
            ST_BW:   begin cmd.op = OP_BW;   state_next = ST_BWU;  end
            ST_BWU:  begin cmd.op = OP_BWU;  state_next = ST_POS;  end
            ST_POS:  begin cmd.op = OP_POS;  state_next = ST_GE;   end
            ST_GE:   begin cmd.op = OP_GE;   state_next = ST_LW;   end
            ST_LW:   begin cmd.op = OP_LW;   state_next = ST_DLIM; end
            ST_DLIM: begin cmd.op = OP_DLIM; state_next = ST_CLMP; end
            ST_CLMP: begin cmd.op = OP_CLMP; state_next = ST_KP;   end
            ST_KP:   begin cmd.op = OP_KP;   state_next = ST_DIV;  end
            ST_DIV:  begin cmd.op = OP_DIVS; state_next = ST_DIVW; end
            ST_DIVW: begin
                if (!stat.div_busy) state_next = ST_COMP;
            end
            ST_COMP: begin cmd.op = OP_COMP; state_next = ST_OUT;  end
            ST_OUT: begin
                out_valid = 1'b1;
                if (out_ready) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_OUT && !out_ready) |=> state_reg == ST_OUT)
        else $error("result dropped under stall");
    assert property (@(posedge aclk) disable iff (!aresetn)
        !(in_ready && out_valid))
        else $error("input taken while result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE && in_valid) |=> state_reg == ST_THR)
        else $error("accepted transaction not started");

endmodule
`default_nettype wire

FILE: hdl/leso_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// leso_dp
// Datapath: shared rounding multiplier, saturating adders, serial divider.
// ----------------------------------------------------------------------------
module leso_dp
    import leso_pkg::*;
(
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire cmd_t                 cmd,
    output status_t                   stat,
    input  wire logic signed [DW-1:0] target,
    input  wire logic signed [DW-1:0] measured,
    input  wire logic signed [DW-1:0] applied_control,
    input  wire logic [11:0]          throttle,
    input  wire logic [16:0]          step_time,
    input  wire logic [30:0]          dist_gain,
    input  wire logic [30:0]          model_gain,
    input  wire logic [30:0]          dead_zone,
    input  wire logic [30:0]          error_limit,
    input  wire logic [30:0]          prop_gain,
    input  wire logic [30:0]          output_limit,
    input  wire logic                 use_own_error,
    output logic signed [DW-1:0]      control_out
);

    localparam logic signed [DW+1:0] DMAX = (34'sd1 <<< (DW-1)) - 34'sd1;
    localparam logic signed [DW+1:0] DMIN = -(34'sd1 <<< (DW-1));
    localparam logic signed [DW-1:0] ONE  = 32'sd1 <<< FB;
    localparam logic signed [DW-1:0] K_FILT = 32'sd2057830;
    localparam logic signed [DW-1:0] K_WEIGHT = 32'sd7 <<< (FB-2);
    // ceil(2^29/25): exact floor of (thr*4096)/25 for every 12-bit throttle
    localparam logic [24:0] RECIP25 = 25'd21474837;

    function automatic logic signed [DW-1:0] sat(input logic signed [DW+1:0] v);
        if (v > DMAX) return DMAX[DW-1:0];
        if (v < DMIN) return DMIN[DW-1:0];
        return v[DW-1:0];
    endfunction

    function automatic logic signed [DW-1:0] dzf(input logic signed [DW-1:0] x,
                                                  input logic signed [DW-1:0] z);
        logic signed [DW+1:0] t;
        if (x > 0) begin
            t = 34'(x) - 34'(z);
            if (t < 0) t = '0;
        end else begin
            t = 34'(x) + 34'(z);
            if (t > 0) t = '0;
        end
        return sat(t);
    endfunction

    // one 32x32 rounding multiply
    function automatic logic signed [DW-1:0] mulq(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        logic        neg;
        logic [32:0] ua, ub;
        logic [65:0] p;
        logic [65:0] m;
        neg = (a < 0) != (b < 0);
        ua  = a < 0 ? 33'(-34'(a)) : 33'(a);
        ub  = b < 0 ? 33'(-34'(b)) : 33'(b);
        p   = 66'(ua * ub) + (66'd1 << (FB-1));
        m   = p >> FB;
        if (neg) begin
            if (m > 66'h80000000) return DMIN[DW-1:0];
            return DW'(-m);
        end
        if (m > 66'h7fffffff) return DMAX[DW-1:0];
        return DW'(m);
    endfunction

    logic signed [DW-1:0] v_reg, y_reg, u_reg;
    logic [11:0]          thr_reg;
    logic signed [DW-1:0] pos_reg, dist_reg, filt_reg, held_reg;
    logic signed [DW-1:0] x_reg, kh_reg, w_reg, bw_reg, inner_reg, e_reg;
    logic signed [DW-1:0] lw_reg, dlim_reg, e1_reg, ctl_reg;

    logic signed [DW-1:0] g1, b0, dead, elim, kp, lim, h;
    assign h    = DW'(step_time);
    assign g1   = DW'(dist_gain);
    assign b0   = DW'(model_gain);
    assign dead = DW'(dead_zone);
    assign elim = DW'(error_limit);
    assign kp   = DW'(prop_gain);
    assign lim  = DW'(output_limit);

    // restoring divider, one quotient bit per cycle
    logic        div_busy_reg;
    logic        div_done_reg;
    logic [5:0]  div_cnt_reg;
    logic [63:0] div_rem_reg;
    logic [63:0] div_q_reg;
    logic        div_neg_reg;
    logic [64:0] div_trial;
    assign div_trial = {div_rem_reg, div_q_reg[63]} - 65'(b0);
    assign stat.div_busy = div_busy_reg;

    logic [36:0] thr_prod;
    logic [19:0] thr_q;
    assign thr_prod = 37'(thr_reg) * 37'(RECIP25);
    assign thr_q    = thr_prod[36:17];

    logic signed [DW-1:0] mul_a, mul_b, mul_r;
    logic signed [DW-1:0] wv, np, e1v, quo;
    logic [63:0] qmag;

    always_comb begin
        e1v = use_own_error ? dzf(sat(34'(v_reg) - 34'(pos_reg)), dead) : '0;
    end

    always_comb begin
        mul_a = '0;
        mul_b = '0;
        case (cmd.op)
            OP_KH:   begin mul_a = K_FILT;   mul_b = h; end
            OP_FILT: begin mul_a = kh_reg;   mul_b = sat(34'(x_reg) - 34'(filt_reg)); end
            OP_WGT:  begin mul_a = K_WEIGHT; mul_b = filt_reg; end
            OP_BW:   begin mul_a = b0;       mul_b = w_reg; end
            OP_BWU:  begin mul_a = bw_reg;   mul_b = u_reg; end
            OP_POS:  begin mul_a = h;        mul_b = inner_reg; end
            OP_GE:   begin mul_a = g1;       mul_b = e_reg; end
            OP_LW:   begin mul_a = lim;      mul_b = w_reg; end
            OP_DLIM: begin mul_a = lw_reg;   mul_b = sat(34'(b0) + 34'(ONE)); end
            OP_KP:   begin
                mul_a = kp;
                mul_b = (elim > 0) ? ((e1v > elim) ? elim :
                        (e1v < -elim) ? -elim : e1v) : e1v;
            end
            OP_COMP: begin mul_a = w_reg;    mul_b = held_reg; end
            default: ;
        endcase
        mul_r = mulq(mul_a, mul_b);
    end

    always_comb begin
        wv  = (mul_r < 0) ? '0 : (mul_r > ONE) ? ONE : mul_r;
        np  = sat(34'(pos_reg) + 34'(mul_r) - 34'(e_reg));
        qmag = (div_q_reg[63:FB] > 64'(DMAX >>> FB)) ? 64'h80000000 : div_q_reg;
        if (div_neg_reg) quo = (qmag > 64'h80000000) ? DMIN[DW-1:0] : DW'(-qmag);
        else quo = (qmag > 64'h7fffffff) ? DMAX[DW-1:0] : DW'(qmag);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg      <= '0;
            dist_reg     <= '0;
            filt_reg     <= '0;
            held_reg     <= '0;
            div_busy_reg <= 1'b0;
        end else begin
            if (cmd.load) begin
                v_reg   <= target;
                y_reg   <= measured;
                u_reg   <= applied_control;
                thr_reg <= throttle;
            end
            case (cmd.op)
                OP_THR:  x_reg <= DW'(thr_q);
                OP_KH:   kh_reg <= mul_r;
                OP_FILT: filt_reg <= sat(34'(filt_reg) + 34'(mul_r));
                OP_WGT: begin
                    w_reg <= wv;
                    e_reg <= dzf(sat(34'(pos_reg) - 34'(y_reg)), dead);
                end
                OP_BW:   bw_reg <= mul_r;
                OP_BWU:  inner_reg <= sat(34'(dist_reg) + 34'(mul_r));
                OP_POS:  pos_reg <= np;
                OP_GE:   dist_reg <= sat(34'(dist_reg) - 34'(mul_r));
                OP_LW:   lw_reg <= mul_r;
                OP_DLIM: dlim_reg <= mul_r;
                OP_CLMP: begin
                    if (dist_reg > dlim_reg) dist_reg <= dlim_reg;
                    else if (dist_reg < -dlim_reg) dist_reg <= -dlim_reg;
                end
                OP_KP: begin
                    ctl_reg <= mul_r;
                    e1_reg  <= e1v;
                end
                OP_DIVS: begin
                    // dividend |dist| << FB, shifted in MSB first
                    if (b0 != 0 && (e1_reg > dead || e1_reg < -dead)) begin
                        div_busy_reg <= 1'b1;
                        div_cnt_reg  <= '0;
                        div_rem_reg  <= '0;
                        div_neg_reg  <= dist_reg < 0;
                        div_q_reg    <= (dist_reg < 0 ? 64'(-65'(dist_reg))
                                                      : 64'(dist_reg)) << FB;
                    end
                end
                OP_COMP: begin
                    if (b0 != 0)
                        ctl_reg <= sat(34'(ctl_reg) - 34'(mul_r));
                end
                default: ;
            endcase
            if (div_busy_reg) begin
                if (!div_trial[64]) begin
                    div_rem_reg <= div_trial[63:0];
                    div_q_reg   <= {div_q_reg[62:0], 1'b1};
                end else begin
                    div_rem_reg <= {div_rem_reg[62:0], div_q_reg[63]};
                    div_q_reg   <= {div_q_reg[62:0], 1'b0};
                end
                div_cnt_reg <= div_cnt_reg + 6'd1;
                if (div_cnt_reg == 6'd63) div_busy_reg <= 1'b0;
            end
            // latch quotient the cycle after the divider finishes
            if (div_done_reg) held_reg <= quo;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) div_done_reg <= 1'b0;
        else div_done_reg <= div_busy_reg && div_cnt_reg == 6'd63;
    end

    assign control_out = (ctl_reg > lim) ? lim : (ctl_reg < -lim) ? -lim : ctl_reg;

endmodule
`default_nettype wire

FILE: hdl/linear_eso_disturbance_rejection_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// linear_eso_disturbance_rejection_top
// Second-order linear ESO controller with proportional feedback.
// ----------------------------------------------------------------------------
// Input stream s_axis: target, measured, applied control and throttle per sample.
// Output stream m_axis: one control value per sample.
// Registers are written through cfg_we / cfg_addr / cfg_wdata; the user must
// write them only while idle, as the block itself does not enforce it.
// One sample at a time: after the accepting edge the sequencer walks 13
// datapath steps, a divider wait state and a compensation step, then raises
// m_tvalid. When the held compensation refreshes, the 64-step bit-serial
// divider stretches the wait before m_tvalid rises. The next sample is taken
// only after the result has been taken and the sequencer is back in idle.
// Reset clears the observer state and loads register defaults.
// While the receiver stalls the result holds and no input is taken.
// ----------------------------------------------------------------------------
module linear_eso_disturbance_rejection_top
    import leso_pkg::*;
(
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // target[31:0], measured[63:32], applied_control[95:64], throttle[107:96]
    input  wire logic [111:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // control_out[31:0]
    output logic [31:0]       m_tdata,
    input  wire logic         cfg_we,
    input  wire logic [2:0]   cfg_addr,
    input  wire logic [30:0]  cfg_wdata
);

    logic [16:0] step_reg;
    logic [30:0] dg_reg, mg_reg, dz_reg, el_reg, kp_reg, ol_reg;
    logic        uoe_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg <= 17'd66;
            dg_reg   <= 31'd2184533;
            mg_reg   <= 31'd1310720;
            dz_reg   <= '0;
            el_reg   <= '0;
            kp_reg   <= 31'd65536;
            ol_reg   <= 31'd32768000;
            uoe_reg  <= 1'b1;
        end else if (cfg_we) begin
            unique case (cfg_addr)
                REG_STEP: step_reg <= cfg_wdata[16:0];
                REG_DG:   dg_reg   <= cfg_wdata;
                REG_MG:   mg_reg   <= cfg_wdata;
                REG_DZ:   dz_reg   <= cfg_wdata;
                REG_EL:   el_reg   <= cfg_wdata;
                REG_KP:   kp_reg   <= cfg_wdata;
                REG_OL:   ol_reg   <= cfg_wdata;
                REG_UOE:  uoe_reg  <= cfg_wdata[0];
                default: ;
            endcase
        end
    end

    cmd_t    cmd;
    status_t stat;
    logic signed [DW-1:0] ctl;

    leso_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_tvalid), .in_ready(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready),
        .stat(stat), .cmd(cmd)
    );

    leso_dp u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .target(s_tdata[31:0]), .measured(s_tdata[63:32]),
        .applied_control(s_tdata[95:64]), .throttle(s_tdata[107:96]),
        .step_time(step_reg), .dist_gain(dg_reg), .model_gain(mg_reg),
        .dead_zone(dz_reg), .error_limit(el_reg), .prop_gain(kp_reg),
        .output_limit(ol_reg), .use_own_error(uoe_reg),
        .control_out(ctl)
    );

    assign m_tdata = ctl;

endmodule
`default_nettype wire
